### design/rdbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdbf_pkg: shared types and constants for the rotor drag block
// Field widths, derived pipeline widths, register codes and stage control.
// ----------------------------------------------------------------------------
package rdbf_pkg;

  // rotor inputs
  localparam int ROTOR_COUNT  = 4;
  localparam int ROTOR_FIELDS = 4;
  localparam int ROTOR_USED   = (ROTOR_COUNT < ROTOR_FIELDS) ? ROTOR_COUNT : ROTOR_FIELDS;

  // input fields
  localparam int FIELD_W     = 16;
  localparam int QUAT_N      = 4;
  localparam int AXIS_N      = 3;
  localparam int IN_FIELDS   = QUAT_N + AXIS_N + ROTOR_FIELDS;
  localparam int IN_TDATA_W  = IN_FIELDS * FIELD_W;

  // drag scaling
  localparam int SUM_W   = FIELD_W - 1 + $clog2(ROTOR_USED);
  localparam int COEFF_W = 24;
  localparam int MAG_W   = FIELD_W;
  localparam int P1_W    = COEFF_W + SUM_W;
  localparam int SPLIT_W = 24;
  localparam int HI_W    = P1_W - SPLIT_W;
  localparam int DPROD_W = P1_W + MAG_W;
  localparam int DRAG_SH = 27;
  localparam int D_W     = DPROD_W - DRAG_SH + 2;

  // rotation
  localparam int PROD_W  = 2 * FIELD_W;
  localparam int E_W     = PROD_W + 1;
  localparam int PP_W    = E_W + D_W;
  localparam int F_W     = PP_W + 3;
  localparam int OUT_SH  = 28;
  localparam int R_W     = F_W - OUT_SH + 1;

  // outputs
  localparam int FORCE_W     = 32;
  localparam int OUT_TDATA_W = AXIS_N * FORCE_W;

  // configuration
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COEFF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAG_ENABLE,
    REG_COEFF_X,
    REG_COEFF_Y,
    REG_COEFF_Z
  } cfg_reg_t;

  typedef logic signed [FIELD_W-1:0] sfield_t;
  typedef logic        [COEFF_W-1:0] coeff_t;
  typedef logic signed [D_W-1:0]     drag_t;
  typedef logic signed [E_W-1:0]     ent_t;
  typedef logic signed [PROD_W-1:0]  qprod_t;
  typedef logic        [FORCE_W-1:0] force_t;

  // control that travels with each request
  typedef struct packed {
    logic valid;
    logic reject;
  } ctl_t;

endpackage

### design/rdbf_drag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdbf_drag: world-frame drag force
// Sums rotor speeds, scales each axis velocity by -coeff * sum, rounds to
// Q16.16. Four stages: sum/abs, coeff*sum, split product, recombine/round.
// ----------------------------------------------------------------------------
module rdbf_drag (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic                drag_enable,
  input  rdbf_pkg::coeff_t    coeff [rdbf_pkg::AXIS_N],
  input  rdbf_pkg::sfield_t   vel   [rdbf_pkg::AXIS_N],
  input  rdbf_pkg::sfield_t   rotor [rdbf_pkg::ROTOR_FIELDS],
  output rdbf_pkg::ctl_t      ctl_o,
  output rdbf_pkg::drag_t     d_o   [rdbf_pkg::AXIS_N]
);

  // stage 1: rotor sum, reject, velocity magnitude
  rdbf_pkg::ctl_t                  ctl1_nxt, ctl1_r;
  logic [rdbf_pkg::SUM_W-1:0]      sum1_nxt, sum1_r;
  logic [rdbf_pkg::MAG_W-1:0]      mag1_nxt [rdbf_pkg::AXIS_N];
  logic [rdbf_pkg::MAG_W-1:0]      mag1_r   [rdbf_pkg::AXIS_N];
  logic [rdbf_pkg::AXIS_N-1:0]     neg1_nxt, neg1_r;

  always_comb begin
    ctl1_nxt.valid  = in_valid;
    ctl1_nxt.reject = !drag_enable;
    sum1_nxt        = '0;
    for (int i = 0; i < rdbf_pkg::ROTOR_USED; i++) begin
      // a negative speed rejects; its bits never reach a kept sum
      if (rotor[i][rdbf_pkg::FIELD_W-1]) begin
        ctl1_nxt.reject = 1'b1;
      end
      sum1_nxt = sum1_nxt + rdbf_pkg::SUM_W'(rotor[i][rdbf_pkg::FIELD_W-2:0]);
    end
    for (int a = 0; a < rdbf_pkg::AXIS_N; a++) begin
      neg1_nxt[a] = vel[a][rdbf_pkg::FIELD_W-1];
      mag1_nxt[a] = neg1_nxt[a] ? rdbf_pkg::MAG_W'(-vel[a]) : rdbf_pkg::MAG_W'(vel[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r <= sum1_nxt;
      mag1_r <= mag1_nxt;
      neg1_r <= neg1_nxt;
    end
  end

  // stage 2: coeff * sum
  rdbf_pkg::ctl_t                  ctl2_r;
  logic [rdbf_pkg::P1_W-1:0]       p1_nxt [rdbf_pkg::AXIS_N];
  logic [rdbf_pkg::P1_W-1:0]       p1_r   [rdbf_pkg::AXIS_N];
  logic [rdbf_pkg::MAG_W-1:0]      mag2_r [rdbf_pkg::AXIS_N];
  logic [rdbf_pkg::AXIS_N-1:0]     neg2_r;

  always_comb begin
    for (int a = 0; a < rdbf_pkg::AXIS_N; a++) begin
      p1_nxt[a] = coeff[a] * sum1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p1_nxt;
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
    end
  end

  // stage 3: two partial products against the velocity magnitude
  localparam int LO_PW = rdbf_pkg::SPLIT_W + rdbf_pkg::MAG_W;
  localparam int HI_PW = rdbf_pkg::HI_W + rdbf_pkg::MAG_W;

  rdbf_pkg::ctl_t                  ctl3_r;
  logic [LO_PW-1:0]                lo_nxt [rdbf_pkg::AXIS_N];
  logic [LO_PW-1:0]                lo_r   [rdbf_pkg::AXIS_N];
  logic [HI_PW-1:0]                hi_nxt [rdbf_pkg::AXIS_N];
  logic [HI_PW-1:0]                hi_r   [rdbf_pkg::AXIS_N];
  logic [rdbf_pkg::AXIS_N-1:0]     neg3_r;

  always_comb begin
    for (int a = 0; a < rdbf_pkg::AXIS_N; a++) begin
      lo_nxt[a] = p1_r[a][rdbf_pkg::SPLIT_W-1:0] * mag2_r[a];
      hi_nxt[a] = p1_r[a][rdbf_pkg::P1_W-1:rdbf_pkg::SPLIT_W] * mag2_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (en) begin
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      neg3_r <= neg2_r;
    end
  end

  // stage 4: recombine, round half away from zero, sign opposite to velocity
  rdbf_pkg::ctl_t                  ctl4_r;
  rdbf_pkg::drag_t                 d4_nxt [rdbf_pkg::AXIS_N];
  rdbf_pkg::drag_t                 d4_r   [rdbf_pkg::AXIS_N];
  logic [rdbf_pkg::DPROD_W-1:0]    prod;
  logic [rdbf_pkg::DPROD_W:0]      rnd;
  rdbf_pkg::drag_t                 dmag;

  always_comb begin
    prod = '0;
    rnd  = '0;
    dmag = '0;
    for (int a = 0; a < rdbf_pkg::AXIS_N; a++) begin
      prod = {hi_r[a], {rdbf_pkg::SPLIT_W{1'b0}}} + rdbf_pkg::DPROD_W'(lo_r[a]);
      rnd  = (rdbf_pkg::DPROD_W + 1)'(prod)
           + ((rdbf_pkg::DPROD_W + 1)'(1) << (rdbf_pkg::DRAG_SH - 1));
      dmag = {1'b0, rnd[rdbf_pkg::DPROD_W:rdbf_pkg::DRAG_SH]};
      d4_nxt[a] = neg3_r[a] ? dmag : -dmag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else if (en) begin
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4_r <= d4_nxt;
    end
  end

  assign ctl_o = ctl4_r;
  assign d_o   = d4_r;

endmodule

### design/rdbf_rotmat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdbf_rotmat: transposed rotation matrix from an unnormalized quaternion
// Stage 1 forms the ten component products, stage 2 the nine entries
// (off-diagonal entries at half value), stages 3-4 align with the drag path.
// ----------------------------------------------------------------------------
module rdbf_rotmat (
  input  logic                clk,
  input  logic                en,
  input  rdbf_pkg::sfield_t   quat  [rdbf_pkg::QUAT_N],
  output rdbf_pkg::ent_t      ent_o [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N]
);

  localparam int QX = 0;
  localparam int QY = 1;
  localparam int QZ = 2;
  localparam int QW = 3;

  // stage 1: component products
  rdbf_pkg::qprod_t ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= quat[QW] * quat[QW];
      xx_r <= quat[QX] * quat[QX];
      yy_r <= quat[QY] * quat[QY];
      zz_r <= quat[QZ] * quat[QZ];
      xy_r <= quat[QX] * quat[QY];
      xz_r <= quat[QX] * quat[QZ];
      yz_r <= quat[QY] * quat[QZ];
      wx_r <= quat[QW] * quat[QX];
      wy_r <= quat[QW] * quat[QY];
      wz_r <= quat[QW] * quat[QZ];
    end
  end

  // stage 2: matrix entries, row = body axis, column = world axis
  rdbf_pkg::ent_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  rdbf_pkg::ent_t ent2_nxt [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N];
  rdbf_pkg::ent_t ent2_r   [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N];
  rdbf_pkg::ent_t ent3_r   [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N];
  rdbf_pkg::ent_t ent4_r   [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N];

  always_comb begin
    ww = rdbf_pkg::E_W'(ww_r);
    xx = rdbf_pkg::E_W'(xx_r);
    yy = rdbf_pkg::E_W'(yy_r);
    zz = rdbf_pkg::E_W'(zz_r);
    xy = rdbf_pkg::E_W'(xy_r);
    xz = rdbf_pkg::E_W'(xz_r);
    yz = rdbf_pkg::E_W'(yz_r);
    wx = rdbf_pkg::E_W'(wx_r);
    wy = rdbf_pkg::E_W'(wy_r);
    wz = rdbf_pkg::E_W'(wz_r);
    ent2_nxt[0][0] = ww + xx - yy - zz;
    ent2_nxt[0][1] = xy + wz;
    ent2_nxt[0][2] = xz - wy;
    ent2_nxt[1][0] = xy - wz;
    ent2_nxt[1][1] = ww - xx + yy - zz;
    ent2_nxt[1][2] = yz + wx;
    ent2_nxt[2][0] = xz + wy;
    ent2_nxt[2][1] = yz - wx;
    ent2_nxt[2][2] = ww - xx - yy + zz;
  end

  // stages 2-4: entries ride alongside the drag scaling
  always_ff @(posedge clk) begin
    if (en) begin
      ent2_r <= ent2_nxt;
      ent3_r <= ent2_r;
      ent4_r <= ent3_r;
    end
  end

  assign ent_o = ent4_r;

endmodule

### design/rdbf_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdbf_rotate: body-frame force and output buffer
// Stage 5 multiplies entries by drag, stage 6 sums rows, stage 7 rounds.
// Saturation feeds an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module rdbf_rotate (
  input  logic                clk,
  input  logic                rst_n,
  output logic                en,
  input  rdbf_pkg::ctl_t      ctl_i,
  input  rdbf_pkg::drag_t     d_i     [rdbf_pkg::AXIS_N],
  input  rdbf_pkg::ent_t      ent_i   [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N],
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_reject,
  output rdbf_pkg::force_t    out_force [rdbf_pkg::AXIS_N]
);

  localparam logic signed [rdbf_pkg::R_W-1:0] SAT_HI =
    {{(rdbf_pkg::R_W - rdbf_pkg::FORCE_W + 1){1'b0}}, {(rdbf_pkg::FORCE_W - 1){1'b1}}};
  localparam logic signed [rdbf_pkg::R_W-1:0] SAT_LO =
    {{(rdbf_pkg::R_W - rdbf_pkg::FORCE_W + 1){1'b1}}, {(rdbf_pkg::FORCE_W - 1){1'b0}}};

  logic skid_valid_r;

  // whole pipeline moves unless the skid entry is occupied
  assign en = !skid_valid_r;

  // stage 5: entry * drag products
  rdbf_pkg::ctl_t                 ctl5_r;
  logic signed [rdbf_pkg::PP_W-1:0] pp5_r [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else if (en) begin
      ctl5_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < rdbf_pkg::AXIS_N; r++) begin
        for (int c = 0; c < rdbf_pkg::AXIS_N; c++) begin
          pp5_r[r][c] <= ent_i[r][c] * d_i[c];
        end
      end
    end
  end

  // stage 6: row sums, off-diagonal terms doubled
  rdbf_pkg::ctl_t                   ctl6_r;
  logic signed [rdbf_pkg::F_W-1:0]  f6_nxt [rdbf_pkg::AXIS_N];
  logic signed [rdbf_pkg::F_W-1:0]  f6_r   [rdbf_pkg::AXIS_N];
  logic signed [rdbf_pkg::F_W-1:0]  term;

  always_comb begin
    term = '0;
    for (int r = 0; r < rdbf_pkg::AXIS_N; r++) begin
      f6_nxt[r] = '0;
      for (int c = 0; c < rdbf_pkg::AXIS_N; c++) begin
        term = rdbf_pkg::F_W'(pp5_r[r][c]);
        f6_nxt[r] = f6_nxt[r] + ((r == c) ? term : (term <<< 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r <= '0;
    end else if (en) begin
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f6_r <= f6_nxt;
    end
  end

  // stage 7: round half away from zero to Q16.16
  rdbf_pkg::ctl_t                   ctl7_r;
  logic signed [rdbf_pkg::R_W-1:0]  r7_nxt [rdbf_pkg::AXIS_N];
  logic signed [rdbf_pkg::R_W-1:0]  r7_r   [rdbf_pkg::AXIS_N];
  logic        [rdbf_pkg::F_W-1:0]  fmag;
  logic        [rdbf_pkg::F_W-1:0]  fsum;
  logic signed [rdbf_pkg::R_W-1:0]  rpos;

  always_comb begin
    fmag = '0;
    fsum = '0;
    rpos = '0;
    for (int r = 0; r < rdbf_pkg::AXIS_N; r++) begin
      fmag = f6_r[r][rdbf_pkg::F_W-1] ? -f6_r[r] : f6_r[r];
      fsum = fmag + (rdbf_pkg::F_W'(1) << (rdbf_pkg::OUT_SH - 1));
      rpos = {1'b0, fsum[rdbf_pkg::F_W-1:rdbf_pkg::OUT_SH]};
      r7_nxt[r] = f6_r[r][rdbf_pkg::F_W-1] ? -rpos : rpos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl7_r <= '0;
    end else if (en) begin
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r7_r <= r7_nxt;
    end
  end

  // saturate, zero on reject
  rdbf_pkg::force_t res_force [rdbf_pkg::AXIS_N];
  logic             res_take;

  always_comb begin
    for (int r = 0; r < rdbf_pkg::AXIS_N; r++) begin
      if (ctl7_r.reject) begin
        res_force[r] = '0;
      end else if (r7_r[r] > SAT_HI) begin
        res_force[r] = SAT_HI[rdbf_pkg::FORCE_W-1:0];
      end else if (r7_r[r] < SAT_LO) begin
        res_force[r] = SAT_LO[rdbf_pkg::FORCE_W-1:0];
      end else begin
        res_force[r] = r7_r[r][rdbf_pkg::FORCE_W-1:0];
      end
    end
  end

  assign res_take = en && ctl7_r.valid;

  // output register plus skid entry
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_nxt;
  logic             out_load, skid_load;
  logic             out_reject_r, skid_reject_r;
  rdbf_pkg::force_t out_force_r  [rdbf_pkg::AXIS_N];
  rdbf_pkg::force_t skid_force_r [rdbf_pkg::AXIS_N];

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    skid_load      = 1'b0;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = res_take;
        out_load       = res_take;
      end
    end else if (res_take) begin
      skid_valid_nxt = 1'b1;
      skid_load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_force_r  <= res_force;
      out_reject_r <= ctl7_r.reject;
    end else if ((!out_valid_r || out_ready) && skid_valid_r) begin
      out_force_r  <= skid_force_r;
      out_reject_r <= skid_reject_r;
    end
    if (skid_load) begin
      skid_force_r  <= res_force;
      skid_reject_r <= ctl7_r.reject;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_reject = out_reject_r;
  assign out_force  = out_force_r;

  // a rejected request always leaves with a zero force
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_reject_r |->
      out_force_r[0] == '0 && out_force_r[1] == '0 && out_force_r[2] == '0)
    else $error("rejected result carries a nonzero force");

  // the skid entry only fills behind a waiting output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  // positive x overflow clamps to the largest Q16.16 value
  a_sat_hi: assert property (@(posedge clk) disable iff (!rst_n)
    ctl7_r.valid && !ctl7_r.reject && r7_r[0] > SAT_HI |->
      res_force[0] == SAT_HI[rdbf_pkg::FORCE_W-1:0])
    else $error("x force did not saturate high");

endmodule

### design/rotor_drag_body_frame.sv
`timescale 1ns / 1ps
// An accepted request passes 7 stages and then the output register before out_tvalid.
// Throughput: one request per cycle while the skid entry is empty.
// An output register and one skid entry let the pipeline keep taking requests while a
// result waits; in_tready drops only once the skid entry is occupied.
// Reset (synchronous, rst_n low) clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
// rotor_drag_body_frame: rotor drag rotated into the body frame
// Computes -coeff * sum(rotor) * v per axis and rotates it by conj(q) v q.
// ----------------------------------------------------------------------------
module rotor_drag_body_frame (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // quat_x, quat_y, quat_z, quat_w, air_vel_x, air_vel_y, air_vel_z,
  // rotor_speed_0..3 (16 bits each, from bit 0 up)
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rdbf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // force_x, force_y, force_z (32 bits each, from bit 0 up)
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rdbf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // rejected (bit 0)
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rdbf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdbf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic             drag_enable_r;
  rdbf_pkg::coeff_t coeff_r [rdbf_pkg::AXIS_N];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_enable_r <= 1'b0;
      coeff_r       <= '{default: '0};
    end else if (cfg_valid && cfg_ready) begin
      case (rdbf_pkg::cfg_reg_t'(cfg_index))
        rdbf_pkg::REG_DRAG_ENABLE: drag_enable_r <= cfg_data[0];
        rdbf_pkg::REG_COEFF_X:     coeff_r[0]    <= cfg_data;
        rdbf_pkg::REG_COEFF_Y:     coeff_r[1]    <= cfg_data;
        rdbf_pkg::REG_COEFF_Z:     coeff_r[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input request
  rdbf_pkg::sfield_t quat  [rdbf_pkg::QUAT_N];
  rdbf_pkg::sfield_t vel   [rdbf_pkg::AXIS_N];
  rdbf_pkg::sfield_t rotor [rdbf_pkg::ROTOR_FIELDS];

  always_comb begin
    for (int i = 0; i < rdbf_pkg::QUAT_N; i++) begin
      quat[i] = in_tdata[i*rdbf_pkg::FIELD_W +: rdbf_pkg::FIELD_W];
    end
    for (int a = 0; a < rdbf_pkg::AXIS_N; a++) begin
      vel[a] = in_tdata[(rdbf_pkg::QUAT_N + a)*rdbf_pkg::FIELD_W +: rdbf_pkg::FIELD_W];
    end
    for (int i = 0; i < rdbf_pkg::ROTOR_FIELDS; i++) begin
      rotor[i] = in_tdata[(rdbf_pkg::QUAT_N + rdbf_pkg::AXIS_N + i)*rdbf_pkg::FIELD_W
                          +: rdbf_pkg::FIELD_W];
    end
  end

  logic              en;
  rdbf_pkg::ctl_t    drag_ctl;
  rdbf_pkg::drag_t   drag_d   [rdbf_pkg::AXIS_N];
  rdbf_pkg::ent_t    ent      [rdbf_pkg::AXIS_N][rdbf_pkg::AXIS_N];
  rdbf_pkg::force_t  force_w  [rdbf_pkg::AXIS_N];

  assign in_tready = en;

  rdbf_drag u_drag (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .drag_enable (drag_enable_r),
    .coeff       (coeff_r),
    .vel         (vel),
    .rotor       (rotor),
    .ctl_o       (drag_ctl),
    .d_o         (drag_d)
  );

  rdbf_rotmat u_rotmat (
    .clk   (clk),
    .en    (en),
    .quat  (quat),
    .ent_o (ent)
  );

  rdbf_rotate u_rotate (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ctl_i      (drag_ctl),
    .d_i        (drag_d),
    .ent_i      (ent),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_reject (out_tuser),
    .out_force  (force_w)
  );

  assign out_tdata = {force_w[2], force_w[1], force_w[0]};

  // an enable write lands in the register on the next edge
  a_cfg_enable: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == rdbf_pkg::REG_DRAG_ENABLE |=>
      drag_enable_r == $past(cfg_data[0]))
    else $error("drag enable write lost");

endmodule

### tb/sv/rotor_drag_body_frame_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_drag_body_frame_test: self-checking bench for the rotor drag block
// Drives vehicle samples and register writes, predicts each body-frame force
// in fixed point and compares every result in order. Random gaps on the input
// side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module rotor_drag_body_frame_test;
  import rdbf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic signed [63:0] FORCE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] FORCE_MIN = -64'sd2147483648;

  typedef logic [IN_TDATA_W-1:0] sample_t;

  // expected result, one per request
  typedef struct packed {
    logic   rejected;
    force_t force_z;
    force_t force_y;
    force_t force_x;
  } drag_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  sample_t               in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register copy used by the predictor
  logic         model_enable = 1'b0;
  coeff_t       model_coeff [AXIS_N];

  drag_result_t expected_forces [$];
  drag_result_t want;
  int           fail_count = 0;
  bit           src_calm = 1'b0;
  int           sink_hold = 0;
  int           sink_free = 0;
  int           sink_roll;

  rotor_drag_body_frame dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic longint field_at(input sample_t s, input int idx);
    sfield_t raw;
    raw = s[idx*FIELD_W +: FIELD_W];
    return longint'(raw);
  endfunction

  // round half away from zero by 2^28, then clamp to 32 bits
  function automatic force_t round_clamp(input longint f);
    longint mag;
    logic signed [63:0] r;
    mag = (f < 0) ? -f : f;
    mag = (mag + (longint'(1) << 27)) >> 28;
    r = (f < 0) ? -mag : mag;
    if (r > FORCE_MAX) r = FORCE_MAX;
    if (r < FORCE_MIN) r = FORCE_MIN;
    return r[FORCE_W-1:0];
  endfunction

  function automatic drag_result_t predict_body_force(input sample_t s);
    drag_result_t res;
    longint qx, qy, qz, qw, rotor, sum, vel, mag, prod, r;
    longint d [AXIS_N];
    longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint fx, fy, fz;
    bit     reject;
    reject = !model_enable;
    sum = 0;
    for (int i = 0; i < ROTOR_USED; i++) begin
      rotor = field_at(s, QUAT_N + AXIS_N + i);
      if (rotor < 0) reject = 1'b1;
      else sum += rotor;
    end
    res = '0;
    if (reject) begin
      res.rejected = 1'b1;
      return res;
    end
    // world-frame drag per axis, LSB 2^-43 rounded to 2^-16
    for (int a = 0; a < AXIS_N; a++) begin
      vel  = field_at(s, QUAT_N + a);
      mag  = (vel < 0) ? -vel : vel;
      prod = longint'(model_coeff[a]) * sum * mag;
      r    = (prod + (longint'(1) << 26)) >> 27;
      d[a] = (vel < 0) ? r : -r;
    end
    qx = field_at(s, 0);
    qy = field_at(s, 1);
    qz = field_at(s, 2);
    qw = field_at(s, 3);
    ww = qw * qw; xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; xz = qx * qz; yz = qy * qz;
    wx = qw * qx; wy = qw * qy; wz = qw * qz;
    // transpose of the unnormalized rotation matrix
    fx = (ww + xx - yy - zz) * d[0] + 2 * (xy + wz) * d[1] + 2 * (xz - wy) * d[2];
    fy = 2 * (xy - wz) * d[0] + (ww - xx + yy - zz) * d[1] + 2 * (yz + wx) * d[2];
    fz = 2 * (xz + wy) * d[0] + 2 * (yz - wx) * d[1] + (ww - xx - yy + zz) * d[2];
    res.force_x = round_clamp(fx);
    res.force_y = round_clamp(fy);
    res.force_z = round_clamp(fz);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%08h) actual %0d (0x%08h)",
               $time, name, $signed(exp_v), exp_v, $signed(act_v), act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_forces.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual force 0x%024h rejected %0b",
                 $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_forces.pop_front();
        check_field("force_x", want.force_x, out_tdata[0*FORCE_W +: FORCE_W]);
        check_field("force_y", want.force_y, out_tdata[1*FORCE_W +: FORCE_W]);
        check_field("force_z", want.force_z, out_tdata[2*FORCE_W +: FORCE_W]);
        check_field("rejected", {31'd0, want.rejected}, {31'd0, out_tuser});
      end
    end
  end

  // result-side back-pressure: mostly short stalls, some long, some free runs
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold--;
    end else if (sink_free > 0) begin
      out_tready <= 1'b1;
      sink_free--;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 55) begin
        out_tready <= 1'b1;
      end else if (sink_roll < 85) begin
        out_tready <= 1'b0;
        sink_hold = $urandom_range(0, 2);
      end else if (sink_roll < 95) begin
        out_tready <= 1'b1;
        sink_free = $urandom_range(20, 80);
      end else begin
        out_tready <= 1'b0;
        sink_hold = $urandom_range(8, 40);
      end
    end
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("rotor_drag_body_frame regression: fail");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  function automatic sample_t pack_sample(
    input sfield_t qx, input sfield_t qy, input sfield_t qz, input sfield_t qw,
    input sfield_t vx, input sfield_t vy, input sfield_t vz,
    input sfield_t r0, input sfield_t r1, input sfield_t r2, input sfield_t r3);
    return {r3, r2, r1, r0, vz, vy, vx, qw, qz, qy, qx};
  endfunction

  function automatic int next_gap();
    int roll;
    if (src_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 80) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // full-range word with extra weight on the extremes
  function automatic sfield_t rand_word(input bit nonneg);
    sfield_t w;
    case ($urandom_range(0, 19))
      0:       w = 16'sh8000;
      1:       w = 16'sh7fff;
      2:       w = '0;
      default: w = $urandom;
    endcase
    if (nonneg) w[FIELD_W-1] = 1'b0;
    return w;
  endfunction

  function automatic sfield_t small_word();
    return sfield_t'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic sample_t random_sample();
    sfield_t q [QUAT_N];
    sfield_t v [AXIS_N];
    sfield_t r [ROTOR_FIELDS];
    bit      clean_rotors;
    if ($urandom_range(0, 99) < 35) begin
      // close to a unit attitude
      for (int i = 0; i < 3; i++) q[i] = small_word();
      q[3] = sfield_t'(int'($urandom_range(14336, 18431)));
      if ($urandom_range(0, 1)) q[3] = -q[3];
    end else begin
      for (int i = 0; i < QUAT_N; i++) q[i] = rand_word(1'b0);
    end
    for (int i = 0; i < AXIS_N; i++) v[i] = rand_word(1'b0);
    clean_rotors = ($urandom_range(0, 99) < 85);
    for (int i = 0; i < ROTOR_FIELDS; i++) r[i] = rand_word(clean_rotors);
    return pack_sample(q[0], q[1], q[2], q[3], v[0], v[1], v[2], r[0], r[1], r[2], r[3]);
  endfunction

  // one request on the input channel; valid stays up until the next gap
  task automatic push_sample(input sample_t s, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    expected_forces.push_back(predict_body_force(s));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input coeff_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRAG_ENABLE: model_enable   = value[0];
      REG_COEFF_X:     model_coeff[0] = value;
      REG_COEFF_Y:     model_coeff[1] = value;
      REG_COEFF_Z:     model_coeff[2] = value;
      default: ;
    endcase
  endtask

  task automatic apply_drag_settings(input logic en, input coeff_t cx, input coeff_t cy,
                                     input coeff_t cz);
    wait_idle();
    write_reg(REG_DRAG_ENABLE, coeff_t'(en));
    write_reg(REG_COEFF_X, cx);
    write_reg(REG_COEFF_Y, cy);
    write_reg(REG_COEFF_Z, cz);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // registers at reset: disabled, so every request is rejected
  task automatic test_reset_state();
    push_sample(pack_sample(0, 0, 0, 16384, 256, -256, 512, 100, 100, 100, 100), 0);
    push_sample(pack_sample(-32768, 32767, -32768, 32767, -32768, 32767, 0,
                            32767, 32767, 32767, 32767), next_gap());
  endtask

  // extreme fields and coefficients, including saturation and odd attitudes
  task automatic test_field_extremes();
    apply_drag_settings(1'b1, 24'hffffff, 24'hffffff, 24'hffffff);
    push_sample(pack_sample(0, 0, 0, 16384, 32767, -32768, 0,
                            32767, 32767, 32767, 32767), 0);
    push_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            32767, 32767, 32767, 32767), 0);
    push_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767), next_gap());
    push_sample(pack_sample(32767, -32768, 0, -1, 1, -1, 256, 0, 0, 0, 1), next_gap());
    push_sample(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    // half-length quaternion: force scaled by a quarter
    push_sample(pack_sample(0, 4096, 0, 7094, 1000, -2000, 3000, 400, 800, 1200, 1600), 0);
    push_sample(pack_sample(11585, 0, 0, 11585, -700, 1500, -32768, 32767, 0, 32767, 0),
                next_gap());
  endtask

  // a negative speed on any rotor rejects the request
  task automatic test_negative_rotor();
    for (int i = 0; i < ROTOR_FIELDS; i++) begin
      push_sample(pack_sample(0, 0, 0, 16384, 2560, 2560, 2560,
                              (i == 0) ? -1 : 800, (i == 1) ? -1 : 800,
                              (i == 2) ? -1 : 800, (i == 3) ? -1 : 800), next_gap());
    end
    push_sample(pack_sample(100, 200, 300, 16000, -2560, 2560, -2560,
                            32767, 32767, 32767, -32768), 0);
  endtask

  // disabled rejects; enabled with zero coefficients gives a zero force
  task automatic test_enable_switch();
    apply_drag_settings(1'b0, 24'hffffff, 24'h123456, 24'h000001);
    push_sample(pack_sample(0, 0, 0, 16384, 2560, 2560, 2560, 800, 800, 800, 800), 0);
    push_sample(pack_sample(-32768, 0, 32767, 0, -32768, 32767, 1, 1, 2, 3, 4), next_gap());
    apply_drag_settings(1'b1, 24'h0, 24'h0, 24'h0);
    push_sample(pack_sample(0, 0, 0, 16384, 32767, -32768, 32767,
                            32767, 32767, 32767, 32767), 0);
    push_sample(pack_sample(32767, 32767, -32768, -32768, 5, -5, 0, 9, 0, 0, 0), next_gap());
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      // occasional stretches with no input gaps
      if (n % 50 == 0) src_calm = ($urandom_range(0, 3) == 0);
      push_sample(random_sample(), next_gap());
    end
    src_calm = 1'b0;
  endtask

  // random traffic across several register settings
  task automatic test_random_settings();
    apply_drag_settings(1'b1, coeff_t'($urandom), coeff_t'($urandom), coeff_t'($urandom));
    run_random(250);
    apply_drag_settings(1'b1, 24'hffffff, 24'hffffff, 24'hffffff);
    run_random(200);
    apply_drag_settings(1'b1, coeff_t'($urandom_range(0, 4095)),
                        coeff_t'($urandom_range(0, 4095)), 24'h0);
    run_random(200);
    apply_drag_settings(1'b0, coeff_t'($urandom), coeff_t'($urandom), coeff_t'($urandom));
    run_random(60);
    apply_drag_settings(1'b1, 24'h0, 24'hffffff, coeff_t'($urandom));
    run_random(240);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DRAG_ENABLE;
    cfg_data  = '0;
    for (int a = 0; a < AXIS_N; a++) model_coeff[a] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_field_extremes();
    test_negative_rotor();
    test_enable_switch();
    test_random_settings();

    // drain, then keep watching for anything extra to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("rotor_drag_body_frame regression: pass");
    end else begin
      $display("rotor_drag_body_frame regression: fail");
    end
    $finish;
  end

endmodule
